// ----- src/rxbf_pkg.sv -----
// rxbf_pkg: shared types and constants for the received-byte fifo block
// depends on nothing; imported by the fifo unit and rxbf_checker
`timescale 1ns / 1ps

package rxbf_pkg;

   // fifo geometry
   localparam int DEPTH = 64;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // fixed field widths
   localparam int BYTE_W  = 8;
   localparam int CMD_W   = 2;
   localparam int LEN_W   = 6;
   localparam int CAUSE_W = 2;
   localparam int CSR_W   = 32;
   localparam int CSRI_W  = 2;
   localparam int TLEN_W  = 3;
   localparam int MATCH_W = 3;

   // item commands
   localparam logic [CMD_W-1:0] CMD_PUSH     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RAW_RD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LINE_RD  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CMD_RD   = 2'd3;

   // stop causes on the closing result
   localparam logic [CAUSE_W-1:0] STOP_LIMIT = 2'd0;
   localparam logic [CAUSE_W-1:0] STOP_EMPTY = 2'd1;
   localparam logic [CAUSE_W-1:0] STOP_FOUND = 2'd2;
   localparam logic [CAUSE_W-1:0] STOP_PUSH  = 2'd3;

   // register indexes
   localparam logic [CSRI_W-1:0] CSR_BLOCK_FULL = 2'd0;
   localparam logic [CSRI_W-1:0] CSR_TAIL_BYTES = 2'd1;
   localparam logic [CSRI_W-1:0] CSR_TAIL_LEN   = 2'd2;

   // register reset values and tail length limit
   localparam logic [CSR_W-1:0]  TAIL_BYTES_RST = 32'h0000_0A0D;
   localparam logic [TLEN_W-1:0] TAIL_LEN_RST   = 3'd2;
   localparam logic [TLEN_W-1:0] TAIL_LEN_MAX   = 3'd4;

   localparam logic [BYTE_W-1:0] NL_BYTE = 8'h0A;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CHECK = 3'b010,
      S_DATA  = 3'b100
   } state_type;

endpackage

// ----- src/rxbf_ram.sv -----
// rxbf_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module rxbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/rx_byte_fifo_with_delimited_reads_unit.sv -----
// rx_byte_fifo_with_delimited_reads_unit: ring fifo of received bytes with
// push, raw read, line read and tail-delimited command read
// depends on rxbf_pkg and rxbf_ram
//
//  channel | ports                         | handshake
//  --------+-------------------------------+---------------------------------
//  request | req_command/push_byte/max_len | taken when start && !busy
//  result  | rsp_* fields                  | rsp_valid for one cycle, no stall
//  config  | csr_index, csr_wdata          | written when csr_valid && csr_ready
//
// a push leaves busy low and its result strobes the next cycle
// after its accepting cycle a read holds busy: per popped byte a stop check that
// sends the address, then the registered ram data; last a stop check, which a line
// read ending on its newline skips; each result strobes the next cycle
// reset is synchronous, active high, and empties the fifo; no clearing pass
// the receiver cannot stall, so results leave as soon as they are formed
`timescale 1ns / 1ps

module rx_byte_fifo_with_delimited_reads_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rxbf_pkg::CMD_W-1:0]   req_command,
   input  logic [rxbf_pkg::BYTE_W-1:0]  req_push_byte,
   input  logic [rxbf_pkg::LEN_W-1:0]   req_max_len,
   output logic                         rsp_valid,
   output logic [rxbf_pkg::BYTE_W-1:0]  rsp_data_byte,
   output logic                         rsp_has_byte,
   output logic                         rsp_last,
   output logic [rxbf_pkg::LEN_W-1:0]   rsp_length,
   output logic [rxbf_pkg::CAUSE_W-1:0] rsp_stop_cause,
   output logic                         rsp_push_dropped,
   output logic                         rsp_full_now,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rxbf_pkg::CSRI_W-1:0]  csr_index,
   input  logic [rxbf_pkg::CSR_W-1:0]   csr_wdata
);

   import rxbf_pkg::*;

   // control state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               full_ff, full_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [MATCH_W-1:0] match_ff, match_in;

   // item registers
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [LEN_W-1:0]   maxl_ff, maxl_in;

   // configuration
   logic               block_ff;
   logic [CSR_W-1:0]   tail_ff;
   logic [TLEN_W-1:0]  tlen_ff;

   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_has_ff, rsp_has_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [CAUSE_W-1:0] rsp_cause_ff, rsp_cause_in;
   logic               rsp_drop_ff, rsp_drop_in;
   logic               rsp_full_ff, rsp_full_in;

   // ram ports
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [BYTE_W-1:0]  ram_rd_data;

   logic               accept;
   logic               empty;
   logic [TLEN_W-1:0]  tlen_eff;
   logic [BYTE_W-1:0]  want_byte;
   logic [IDX_W-1:0]   wr_idx_next;
   logic [IDX_W-1:0]   rd_idx_next;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign empty     = (rd_idx_ff == wr_idx_ff) && !full_ff;
   assign tlen_eff  = (tlen_ff > TAIL_LEN_MAX) ? TAIL_LEN_MAX : tlen_ff;
   assign want_byte = tail_ff[match_ff[1:0]*BYTE_W +: BYTE_W];

   assign wr_idx_next = (wr_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
   assign rd_idx_next = (rd_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;

   // byte store
   rxbf_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (req_push_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      full_in      = full_ff;
      len_in       = len_ff;
      match_in     = match_ff;
      cmd_in       = cmd_ff;
      maxl_in      = maxl_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rsp_has_in   = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_len_in   = '0;
      rsp_cause_in = STOP_LIMIT;
      rsp_drop_in  = 1'b0;
      rsp_full_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               maxl_in  = req_max_len;
               len_in   = '0;
               match_in = '0;
               if (req_command == CMD_PUSH) begin
                  // push: store unless blocked while full
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_cause_in = STOP_PUSH;
                  if (full_ff && block_ff) begin
                     rsp_drop_in = 1'b1;
                     rsp_full_in = full_ff;
                  end else begin
                     ram_wr_en   = 1'b1;
                     wr_idx_in   = wr_idx_next;
                     full_in     = full_ff || (wr_idx_next == rd_idx_ff);
                     rsp_full_in = full_in;
                  end
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            // stop checks in order, else pop one byte
            if (cmd_ff == CMD_CMD_RD && match_ff >= MATCH_W'(tlen_eff)) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_len_in   = len_ff;
               rsp_cause_in = STOP_FOUND;
               rsp_full_in  = full_ff;
               state_in     = S_IDLE;
            end else if (len_ff >= maxl_ff) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_len_in   = len_ff;
               rsp_cause_in = STOP_LIMIT;
               rsp_full_in  = full_ff;
               state_in     = S_IDLE;
            end else if (empty) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_len_in   = len_ff;
               rsp_cause_in = STOP_EMPTY;
               rsp_full_in  = full_ff;
               state_in     = S_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               rd_idx_in = rd_idx_next;
               full_in   = 1'b0;
               state_in  = S_DATA;
            end
         end
         S_DATA: begin
            // popped byte is on the ram output
            if (cmd_ff == CMD_LINE_RD && ram_rd_data == NL_BYTE) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_len_in   = len_ff;
               rsp_cause_in = STOP_FOUND;
               rsp_full_in  = full_ff;
               state_in     = S_IDLE;
            end else begin
               if (cmd_ff == CMD_CMD_RD) begin
                  match_in = (ram_rd_data == want_byte) ? match_ff + 1'b1 : '0;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = ram_rd_data;
               rsp_has_in   = 1'b1;
               len_in       = len_ff + 1'b1;
               state_in     = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      match_ff     <= match_in;
      cmd_ff       <= cmd_in;
      maxl_ff      <= maxl_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_cause_ff <= rsp_cause_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff <= 1'b1;
         tail_ff  <= TAIL_BYTES_RST;
         tlen_ff  <= TAIL_LEN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLOCK_FULL: block_ff <= csr_wdata[0];
            CSR_TAIL_BYTES: tail_ff  <= csr_wdata;
            CSR_TAIL_LEN:   tlen_ff  <= csr_wdata[TLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_byte    = rsp_data_ff;
   assign rsp_has_byte     = rsp_has_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_length       = rsp_len_ff;
   assign rsp_stop_cause   = rsp_cause_ff;
   assign rsp_push_dropped = rsp_drop_ff;
   assign rsp_full_now     = rsp_full_ff;

endmodule

// ----- src/rxbf_checker.sv -----
// rxbf_checker: port-level assertions for the received-byte fifo block
// depends on rxbf_pkg; bound to rx_byte_fifo_with_delimited_reads_unit
`timescale 1ns / 1ps

module rxbf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [rxbf_pkg::CMD_W-1:0]   req_command,
   input logic                         rsp_valid,
   input logic                         rsp_has_byte,
   input logic                         rsp_last,
   input logic [rxbf_pkg::LEN_W-1:0]   rsp_length,
   input logic [rxbf_pkg::CAUSE_W-1:0] rsp_stop_cause,
   input logic                         rsp_push_dropped,
   input logic                         rsp_full_now
);

   import rxbf_pkg::*;

   // a result is either a byte or the closing one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_byte != rsp_last))
      else $error("byte and last flags disagree");

   // a delivered byte means a pop, so the flag is clear
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_byte) |-> (!rsp_full_now && rsp_stop_cause == STOP_LIMIT))
      else $error("byte result with full flag or cause");

   // a read keeps the block busy after it is taken
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command != CMD_PUSH) |=> busy)
      else $error("read item not held busy");

   // a dropped push only happens while full
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_push_dropped) |-> (rsp_full_now && rsp_stop_cause == STOP_PUSH))
      else $error("dropped push without full flag");

   // push results carry no length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stop_cause == STOP_PUSH) |-> (rsp_length == '0 && rsp_last))
      else $error("push result with length");

endmodule

bind rx_byte_fifo_with_delimited_reads_unit rxbf_checker u_rxbf_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_has_byte     (rsp_has_byte),
   .rsp_last         (rsp_last),
   .rsp_length       (rsp_length),
   .rsp_stop_cause   (rsp_stop_cause),
   .rsp_push_dropped (rsp_push_dropped),
   .rsp_full_now     (rsp_full_now)
);
